[rtl/core/mfre_pkg.sv]
`timescale 1ns / 1ps

package mfre_pkg;

   // Width of the signed coordinate arithmetic used for clipping and band limits.
   localparam int COORD_W = 12;
   localparam logic signed [COORD_W-1:0] ONE_S = 1;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_BOX   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   typedef enum logic [6:0] {
      ST_SWEEP  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CLIP   = 7'b0000100,
      ST_BAND   = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_MODIFY = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   // Limits that shape the pixel mask of one column byte.
   typedef struct packed {
      logic                      clear_mode;
      logic signed [COORD_W-1:0] y_lo;
      logic signed [COORD_W-1:0] y_hi;
      logic signed [COORD_W-1:0] top_lim;
      logic signed [COORD_W-1:0] bot_lim;
      logic signed [COORD_W-1:0] left_lim;
      logic signed [COORD_W-1:0] right_lim;
   } mask_ctrl_type;

endpackage

[rtl/core/mfre_frame_ram.sv]
`timescale 1ns / 1ps

module mfre_frame_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mfre_mask_unit.sv]
`timescale 1ns / 1ps

module mfre_mask_unit (
   input  mfre_pkg::mask_ctrl_type                   ctrl,
   input  logic signed [mfre_pkg::COORD_W-1:0]       col,
   input  logic signed [mfre_pkg::COORD_W-1:0]       row_base,
   output logic [7:0]                                mask
);

   import mfre_pkg::*;

   logic                      col_band;
   logic signed [COORD_W-1:0] row [8];

   assign col_band = (col < ctrl.left_lim) || (col > ctrl.right_lim);

   // Each bit of the byte is one row; the eight compares are independent.
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         row[n]  = row_base + COORD_W'(n);
         mask[n] = (row[n] >= ctrl.y_lo) && (row[n] <= ctrl.y_hi) &&
                   (ctrl.clear_mode || col_band ||
                    (row[n] < ctrl.top_lim) || (row[n] > ctrl.bot_lim));
      end
   end

endmodule

[rtl/core/mono_framebuffer_rect_engine.sv]
`timescale 1ns / 1ps

// Monochrome framebuffer with rectangle clear, outlined box and byte read.
// The picture is stored as vertical column bytes (bit n of the byte at page p,
// column c is row 8*p+n) in a single-port-write, registered-read memory of
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) words. After reset the block sweeps the
// memory to zero, one word per cycle, with req_ready low. Each command then
// runs through a small sequencer: the setup states ST_CLIP and ST_BAND clip
// the rectangle and derive the band limits, after which one shared mask unit
// builds the pixel mask of each covered column byte while the sequencer does a
// read-modify-write of that byte in its ST_READ and ST_MODIFY states. One
// command is in work at a time; req_ready is high only while the sequencer
// waits for a command, and a finished result sits in an output register, so a
// new word can be taken while the previous result is still waiting on
// rsp_ready. rsp_area_touched is 1 when a clear or box wrote at least one pixel
// or a read addressed a valid byte; rsp_read_data is the column byte for a read
// and 0 otherwise.
module mono_framebuffer_rect_engine #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic signed [9:0] req_x_pos,
   input  logic signed [9:0] req_y_pos,
   input  logic [9:0]        req_rect_width,
   input  logic [9:0]        req_rect_height,
   input  logic [7:0]        req_thickness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_area_touched
);

   import mfre_pkg::*;

   localparam int NUM_PAGES   = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * NUM_PAGES;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int COL_W       = $clog2(SCREEN_WIDTH);
   localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int ROW_W       = PAGE_W + 3;

   localparam logic signed [COORD_W-1:0] SW_S    = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] SH_S    = COORD_W'(SCREEN_HEIGHT);
   localparam logic signed [COORD_W-1:0] PAGES_S = COORD_W'(NUM_PAGES);
   localparam logic [AW-1:0]             LAST_ADDR = AW'(STORE_BYTES - 1);
   localparam logic [AW-1:0]             ROW_STEP  = AW'(SCREEN_WIDTH);

   state_type state_ff, state_in;

   // Command word captured at acceptance.
   logic [1:0]        op_ff, op_in;
   logic signed [9:0] x_ff, x_in;
   logic signed [9:0] y_ff, y_in;
   logic [9:0]        w_ff, w_in;
   logic [9:0]        h_ff, h_in;
   logic [7:0]        t_ff, t_in;

   // Clipped bounds and walk position.
   logic              go_ff, go_in;
   logic [COL_W-1:0]  x0_ff, x0_in;
   logic [COL_W-1:0]  x1_ff, x1_in;
   logic [ROW_W-1:0]  y0_ff, y0_in;
   logic [ROW_W-1:0]  y1_ff, y1_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] page_last_ff, page_last_in;
   logic [AW-1:0]     row_base_ff, row_base_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [7:0]        data_ff, data_in;
   mask_ctrl_type     ctrl_ff, ctrl_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_touched_ff, rsp_touched_in;

   // Clipping arithmetic.
   logic signed [COORD_W-1:0] xs, ys, x_end, y_end, x_lo, x_hi, y_lo, y_hi;
   logic                      x_ok, y_ok, fill_ok, box_ok, rd_ok;
   logic signed [COORD_W-1:0] t_s, y0_s, y1_s, x0_s, x1_s;

   // Memory and mask unit.
   logic [AW-1:0] mem_addr;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;
   logic [7:0]    byte_mask;

   assign xs    = COORD_W'(x_ff);
   assign ys    = COORD_W'(y_ff);
   assign x_end = xs + $signed(COORD_W'(w_ff)) - ONE_S;
   assign y_end = ys + $signed(COORD_W'(h_ff)) - ONE_S;
   assign x_lo  = xs[COORD_W-1] ? '0 : xs;
   assign y_lo  = ys[COORD_W-1] ? '0 : ys;
   assign x_hi  = (x_end > SW_S - ONE_S) ? SW_S - ONE_S : x_end;
   assign y_hi  = (y_end > SH_S - ONE_S) ? SH_S - ONE_S : y_end;
   assign x_ok  = (xs < SW_S) && (x_lo <= x_hi);
   assign y_ok  = (ys < SH_S) && (y_lo <= y_hi);

   // A clear keeps whatever part of the rectangle lies on screen; a box also
   // needs its origin on screen and a nonzero band.
   assign fill_ok = x_ok && y_ok;
   assign box_ok  = fill_ok && !xs[COORD_W-1] && !ys[COORD_W-1] && (t_ff != '0);
   assign rd_ok   = !xs[COORD_W-1] && (xs < SW_S) && !ys[COORD_W-1] && (ys < PAGES_S);

   assign t_s  = $signed(COORD_W'(t_ff));
   assign x0_s = $signed(COORD_W'(x0_ff));
   assign x1_s = $signed(COORD_W'(x1_ff));
   assign y0_s = $signed(COORD_W'(y0_ff));
   assign y1_s = $signed(COORD_W'(y1_ff));

   assign mem_addr = row_base_ff + AW'(col_ff);

   mfre_mask_unit u_mask (
      .ctrl     (ctrl_ff),
      .col      ($signed(COORD_W'(col_ff))),
      .row_base ($signed(COORD_W'({page_ff, 3'b000}))),
      .mask     (byte_mask)
   );

   mfre_frame_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (mem_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_area_touched = rsp_touched_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      t_in           = t_ff;
      go_in          = go_ff;
      x0_in          = x0_ff;
      x1_in          = x1_ff;
      y0_in          = y0_ff;
      y1_in          = y1_ff;
      col_in         = col_ff;
      page_in        = page_ff;
      page_last_in   = page_last_ff;
      row_base_in    = row_base_ff;
      sweep_in       = sweep_ff;
      data_in        = data_ff;
      ctrl_in        = ctrl_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_touched_in = rsp_touched_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = mem_addr;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            // Zero the frame store one word per cycle after reset.
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            sweep_in    = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_action;
               x_in     = req_x_pos;
               y_in     = req_y_pos;
               w_in     = req_rect_width;
               h_in     = req_rect_height;
               t_in     = req_thickness;
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            case (op_ff)
               ACT_CLEAR: go_in = fill_ok;
               ACT_BOX:   go_in = box_ok;
               ACT_READ:  go_in = rd_ok;
               default:   go_in = 1'b0;
            endcase
            x0_in        = x_lo[COL_W-1:0];
            x1_in        = x_hi[COL_W-1:0];
            y0_in        = y_lo[ROW_W-1:0];
            y1_in        = y_hi[ROW_W-1:0];
            page_last_in = y_hi[ROW_W-1:3];
            if (op_ff == ACT_READ) begin
               col_in  = xs[COL_W-1:0];
               page_in = ys[PAGE_W-1:0];
            end else begin
               col_in  = x_lo[COL_W-1:0];
               page_in = y_lo[ROW_W-1:3];
            end
            state_in = ST_BAND;
         end
         ST_BAND: begin
            // The band limits need no clamp to the clipped size: rows and
            // columns outside the clipped rectangle are never visited.
            ctrl_in.clear_mode = (op_ff == ACT_CLEAR);
            ctrl_in.y_lo       = y0_s;
            ctrl_in.y_hi       = y1_s;
            ctrl_in.top_lim    = y0_s + t_s;
            ctrl_in.bot_lim    = y1_s - t_s;
            ctrl_in.left_lim   = x0_s + t_s;
            ctrl_in.right_lim  = x1_s - t_s;
            row_base_in        = AW'(page_ff) * ROW_STEP;
            data_in            = '0;
            state_in           = go_ff ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == ACT_READ) begin
               data_in  = ram_rd_data;
               state_in = ST_DONE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ctrl_ff.clear_mode ? (ram_rd_data & ~byte_mask)
                                                : (ram_rd_data | byte_mask);
               if (col_ff == x1_ff) begin
                  if (page_ff == page_last_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     page_in     = page_ff + PAGE_W'(1);
                     row_base_in = row_base_ff + ROW_STEP;
                     col_in      = x0_ff;
                     state_in    = ST_READ;
                  end
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = (op_ff == ACT_READ) ? data_ff : '0;
               rsp_touched_in = go_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      w_ff           <= w_in;
      h_ff           <= h_in;
      t_ff           <= t_in;
      go_ff          <= go_in;
      x0_ff          <= x0_in;
      x1_ff          <= x1_in;
      y0_ff          <= y0_in;
      y1_ff          <= y1_in;
      col_ff         <= col_in;
      page_ff        <= page_in;
      page_last_ff   <= page_last_in;
      row_base_ff    <= row_base_in;
      data_ff        <= data_in;
      ctrl_ff        <= ctrl_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_touched_ff <= rsp_touched_in;
   end

endmodule

[rtl/core/mfre_checker.sv]
`timescale 1ns / 1ps

module mfre_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_area_touched
);

   logic       req_fire, rsp_fire;
   logic [1:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Commands accepted whose result word has not yet been taken.
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The frame store is swept after reset, so no command is taken right away.
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command accepted during the post-reset sweep");

   // A result word always belongs to an accepted command.
   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("result word without an outstanding command");

   // Nonzero read data only comes from a read that hit the screen.
   a_data_implies_touched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_data != 8'd0)) |-> rsp_area_touched)
      else $error("nonzero read data with area_touched low");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_area_touched)))
      else $error("result word changed while stalled");

endmodule

bind mono_framebuffer_rect_engine mfre_checker u_mfre_checker (.*);
